/* rtl/ptkeg_pkg.sv */
`default_nettype none
package ptkeg_pkg;

  localparam int unsigned AXIS_COUNT = 4;
  localparam int unsigned AXIS_SLOTS = 2 * AXIS_COUNT;
  localparam int unsigned RAW_BUTTONS = 16;

  localparam logic [4:0] AXIS_SOURCE_BASE = 5'd16;
  localparam logic [7:0] AXIS_RESET = 8'd127;
  localparam logic [7:0] LOWER_RESET = 8'd50;
  localparam logic [7:0] UPPER_RESET = 8'd200;

  // configuration register indexes
  localparam logic CFG_LOWER_THRESHOLD = 1'b0;
  localparam logic CFG_UPPER_THRESHOLD = 1'b1;

  typedef struct packed {
    logic        pad_valid;
    logic [15:0] buttons_raw;
    logic [7:0]  right_horizontal;
    logic [7:0]  right_vertical;
    logic [7:0]  left_horizontal;
    logic [7:0]  left_vertical;
  } pad_poll_t;

  typedef struct packed {
    logic [4:0] source;
    logic       release_res;
    logic       last_event;
  } key_event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } ptkeg_state_t;

endpackage
`default_nettype wire

/* rtl/pad_to_key_event_generator_unit.sv */
// A valid poll is taken while idle, then its 8 + BUTTON_COUNT event slots are evaluated
// (one event slot per cycle through the shared threshold/edge compare unit); the first event
// is offered in the cycle straight after, then one event per cycle while out_stall is low.
// A new poll is not accepted (in_stall high) until every event of the last one has been
// offered and taken; an invalid poll is taken while idle and dropped.
// Reset (rst, synchronous, active high): idle, thresholds 50 / 200, previous buttons all
// released, previous axes 127.
`default_nettype none
module pad_to_key_event_generator_unit #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ptkeg_pkg::pad_poll_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ptkeg_pkg::key_event_t      out_data,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import ptkeg_pkg::*;

  // event slots: 8 axis directions first, then the buttons from bit 0 upward
  localparam int unsigned SLOTS = AXIS_SLOTS + BUTTON_COUNT;
  localparam int unsigned SLW = $clog2(SLOTS);
  localparam int unsigned BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  ptkeg_state_t state, state_next;
  logic [SLW-1:0] slot;

  logic [7:0] lower_threshold;
  logic [7:0] upper_threshold;

  // stored state of the last valid poll
  logic [BUTTON_COUNT-1:0] prev_buttons;
  logic [7:0]              prev_axes [AXIS_COUNT];

  // poll being worked on
  logic [BUTTON_COUNT-1:0] new_buttons;
  logic [7:0]              new_axes [AXIS_COUNT];

  // per-slot event flag and its direction (1 = release)
  logic [SLOTS-1:0] ev_mask;
  logic [SLOTS-1:0] ev_rel;

  logic                    in_take;
  logic                    out_take;
  logic [BUTTON_COUNT-1:0] poll_pressed;

  // active low on the pins; bits above the raw width are never pressed
  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (i < RAW_BUTTONS) begin
        poll_pressed[i] = ~in_data.buttons_raw[i];
      end else begin
        poll_pressed[i] = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared compare unit: judges one slot per cycle.
  // Axis slot: slot[2:1] picks the axis, slot[0] the high direction.
  // Low direction pressed when value <= lower, high when value >= upper.
  // ---------------------------------------------------------------------------
  logic                    slot_is_axis;
  logic [1:0]              axis_sel;
  logic                    axis_hi;
  logic [7:0]              axis_now;
  logic [7:0]              axis_was;
  logic [7:0]              thr;
  logic [SLW-1:0]          btn_off;
  logic [BW-1:0]           btn_idx;
  logic                    now_on;
  logic                    was_on;
  logic                    slot_event;
  logic                    slot_rel;

  assign slot_is_axis = slot < SLW'(AXIS_SLOTS);
  assign axis_sel     = slot[2:1];
  assign axis_hi      = slot[0];
  assign axis_now     = new_axes[axis_sel];
  assign axis_was     = prev_axes[axis_sel];
  assign thr          = axis_hi ? upper_threshold : lower_threshold;
  assign btn_off      = slot - SLW'(AXIS_SLOTS);
  assign btn_idx      = btn_off[BW-1:0];

  always_comb begin
    if (slot_is_axis) begin
      now_on = axis_hi ? (axis_now >= thr) : (thr >= axis_now);
      was_on = axis_hi ? (axis_was >= thr) : (thr >= axis_was);
    end else begin
      now_on = new_buttons[btn_idx];
      was_on = prev_buttons[btn_idx];
    end
    slot_event = now_on ^ was_on;
    slot_rel   = was_on;
  end

  // ---------------------------------------------------------------------------
  // Emission: lowest pending slot goes out; last when nothing remains above it.
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0] lowest;
  logic [SLOTS-1:0] remaining;
  logic [SLW-1:0]   first_idx;
  logic [SLW-1:0]   first_btn;

  assign lowest    = ev_mask & (~ev_mask + SLOTS'(1));
  assign remaining = ev_mask & ~lowest;
  assign first_btn = first_idx - SLW'(AXIS_SLOTS);

  always_comb begin
    first_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (ev_mask[s]) begin
        first_idx = SLW'(s);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    out_data.release_res = ev_rel[first_idx];
    out_data.last_event  = (remaining == '0);
    if (first_idx < SLW'(AXIS_SLOTS)) begin
      out_data.source = AXIS_SOURCE_BASE + 5'(first_idx);
    end else begin
      out_data.source = 5'(first_btn);
    end
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.pad_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (slot == SLW'(SLOTS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = (ev_mask != '0);
        if (ev_mask == '0) begin
          state_next = ST_IDLE;
        end else if (!out_stall && remaining == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // control and stored poll state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      slot            <= '0;
      lower_threshold <= LOWER_RESET;
      upper_threshold <= UPPER_RESET;
      prev_buttons    <= '0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        prev_axes[a] <= AXIS_RESET;
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_LOWER_THRESHOLD: lower_threshold <= cfg_data;
          CFG_UPPER_THRESHOLD: upper_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        slot <= '0;
      end else if (state == ST_EVAL) begin
        slot <= slot + SLW'(1);
      end
      // commit the poll once every slot has been judged against the old state
      if (state == ST_EVAL && slot == SLW'(SLOTS - 1)) begin
        prev_buttons <= new_buttons;
        for (int a = 0; a < AXIS_COUNT; a++) begin
          prev_axes[a] <= new_axes[a];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      new_buttons <= poll_pressed;
      new_axes[0] <= in_data.right_horizontal;
      new_axes[1] <= in_data.right_vertical;
      new_axes[2] <= in_data.left_horizontal;
      new_axes[3] <= in_data.left_vertical;
    end
    if (state == ST_EVAL) begin
      ev_mask[slot] <= slot_event;
      ev_rel[slot]  <= slot_rel;
    end else if (out_take) begin
      ev_mask <= remaining;
    end
  end

`ifndef SYNTHESIS
  a_take_starts_eval: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.pad_valid |=> state == ST_EVAL && slot == '0)
    else $error("valid poll did not start evaluation");

  a_no_output_in_eval: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> !out_valid)
    else $error("event offered during evaluation");

  a_more_after_non_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_event |=> out_valid)
    else $error("event stream ended without last mark");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last_event |=> !out_valid && state == ST_IDLE)
    else $error("events continued after last mark");
`endif

endmodule
`default_nettype wire
